### rtl/bspq_pkg.sv
// Package for the bounded sorted priority queue.
// Holds the sizing constants, the entry type, command codes and the ordering key.
// Depends on nothing; every other file of the block but bspq_if imports it.
`timescale 1ns / 1ps

package bspq_pkg;

    // Number of entry slots in the store.
    localparam int CAPACITY = 64;
    // Width of a count or a logical position, which runs from 0 to CAPACITY.
    localparam int CW = $clog2(CAPACITY + 1);
    // Width of a physical store address.
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    // Width used when the count is compared with the limit register.
    localparam int LW = (CW > 7) ? CW : 7;
    // Reset value of the limit register.
    localparam logic [6:0] MAX_SIZE_RESET = 7'd64;

    // Command codes; codes 6 and 7 do nothing.
    localparam logic [2:0] CMD_ENQ      = 3'd0;
    localparam logic [2:0] CMD_DEQ      = 3'd1;
    localparam logic [2:0] CMD_PEEK_MIN = 3'd2;
    localparam logic [2:0] CMD_PEEK_MAX = 3'd3;
    localparam logic [2:0] CMD_POP_IDX  = 3'd4;
    localparam logic [2:0] CMD_CLEAR    = 3'd5;

    typedef struct packed {
        logic [15:0]        idx;
        logic signed [31:0] val;
    } t_entry;

    // One cycle of requests from the sequencer to the entry store.
    typedef struct packed {
        logic          rd_en;
        logic [CW-1:0] rd_pos;
        logic          wr_en;
        logic [CW-1:0] wr_pos;
        t_entry        wr_entry;
        logic          advance;
    } t_store_req;

    // Sort key: value with its sign bit flipped above the index, compared unsigned.
    function automatic logic [47:0] order_key(input t_entry e);
        order_key = {e.val[31] ^ 1'b1, e.val[30:0], e.idx};
    endfunction

endpackage

### rtl/bspq_if.sv
// Channel interfaces of the bounded sorted priority queue: input, result, config.
// Each carries valid, ready and its payload; depends on nothing.
`timescale 1ns / 1ps

interface bspq_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic [15:0]        elem_index;
    logic signed [31:0] elem_value;

    modport source (output valid, output command, output elem_index, output elem_value,
                    input ready);
    modport sink (input valid, input command, input elem_index, input elem_value,
                  output ready);
endinterface

interface bspq_out_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic [15:0]        out_index;
    logic signed [31:0] out_value;
    logic [6:0]         entry_count;
    logic               is_empty;
    logic               is_full;

    modport source (output valid, output status, output out_index, output out_value,
                    output entry_count, output is_empty, output is_full, input ready);
    modport sink (input valid, input status, input out_index, input out_value,
                  input entry_count, input is_empty, input is_full, output ready);
endinterface

interface bspq_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] max_size;

    modport source (output valid, output max_size, input ready);
    modport sink (input valid, input max_size, output ready);
endinterface

### rtl/bspq_store.sv
// Entry store of the bounded sorted priority queue: a circular memory of entries.
// Logical positions are offsets from a head pointer. Depends on bspq_pkg.
`timescale 1ns / 1ps

module bspq_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bspq_pkg::t_store_req i_req,
    output bspq_pkg::t_entry    o_rd_entry
);
    import bspq_pkg::*;

    t_entry        r_mem [CAPACITY];
    t_entry        r_rd_entry;
    logic [AW-1:0] r_head;
    logic [AW-1:0] n_head;

    // Map a logical position onto a physical slot; the sum stays below twice the depth.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = (CW + 1)'(head) + (CW + 1)'(pos);
        if (sum >= (CW + 1)'(CAPACITY)) begin
            sum = sum - (CW + 1)'(CAPACITY);
        end
        phys = AW'(sum);
    endfunction

    always_comb begin
        n_head = r_head;
        if (i_req.advance) begin
            n_head = phys(r_head, CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else begin
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[phys(r_head, i_req.wr_pos)] <= i_req.wr_entry;
        end
        if (i_req.rd_en) begin
            r_rd_entry <= r_mem[phys(r_head, i_req.rd_pos)];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule

### rtl/bounded_sorted_priority_queue.sv
// Top level of the bounded sorted priority queue (keep the k smallest entries).
// Depends on bspq_pkg, the channel interfaces in bspq_if and the store bspq_store.
`timescale 1ns / 1ps

// The queue keeps up to min(max_size, CAPACITY) entries of (index, value), sorted
// ascending by the signed Q16.16 value with ties ordered by index. Each input
// transaction carries one command and yields exactly one result transaction. The
// block handles one command at a time: it drops ready after accepting a command and
// raises it again once the result has been taken, so the next command can be
// accepted in the cycle after the result is taken. Entries live in a circular
// memory with a head pointer, so dequeue and pop only move the head.
// Dequeue, clear, unused codes and any read or removal on an empty queue offer
// their result straight after the execute state; peeks and pop read the memory
// first and pass through a fetch state before their result.
// An enqueue is an insertion sort step run by a small sequencer around one shared
// 48-bit key comparator: it walks the stored entries from the largest down, a memory
// read state and then a compare state for each one, shifting larger entries up by
// one slot. The new entry is written in the compare state where the walk stops, or
// in a separate write state when the walk reaches the bottom slot or the queue is
// empty; an enqueue on an empty queue under a limit of zero goes straight from the
// execute state to its result. At or above its limit the largest entry is evicted,
// or the new entry dropped if it is not smaller than the largest. Clear empties the
// queue but keeps max_size. The configuration channel is always ready and should be
// written only while no command is in flight.
module bounded_sorted_priority_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bspq_in_if.sink    i_in,
    bspq_out_if.source o_out,
    bspq_cfg_if.sink   i_cfg
);
    import bspq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_RD    = 7'b0000100,
        S_CMP   = 7'b0001000,
        S_WRNEW = 7'b0010000,
        S_FETCH = 7'b0100000,
        S_RESP  = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    logic [2:0]    r_cmd, n_cmd;
    t_entry        r_new, n_new;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_pos, n_pos;
    logic          r_evict, n_evict;
    logic          r_status, n_status;
    logic [15:0]   r_oidx, n_oidx;
    logic [31:0]   r_oval, n_oval;
    logic [6:0]    r_max_size;

    t_store_req    w_req;
    t_entry        w_rd_entry;
    logic [LW-1:0] w_limit;
    logic          w_below_limit;
    logic          w_greater;

    bspq_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .o_rd_entry (w_rd_entry)
    );

    // Effective limit is the smaller of the register and the store depth.
    always_comb begin
        if (LW'(r_max_size) < LW'(CAPACITY)) begin
            w_limit = LW'(r_max_size);
        end else begin
            w_limit = LW'(CAPACITY);
        end
    end

    assign w_below_limit = LW'(r_count) < w_limit;

    // The shared comparator: is the stored entry just read ordered after the new one?
    assign w_greater = order_key(w_rd_entry) > order_key(r_new);

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_new    = r_new;
        n_count  = r_count;
        n_pos    = r_pos;
        n_evict  = r_evict;
        n_status = r_status;
        n_oidx   = r_oidx;
        n_oval   = r_oval;
        w_req    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_cmd     = i_in.command;
                    n_new.idx = i_in.elem_index;
                    n_new.val = i_in.elem_value;
                    n_status  = 1'b0;
                    n_oidx    = '0;
                    n_oval    = '0;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
                case (r_cmd)
                    CMD_ENQ: begin
                        // Start the downward walk with the slot just past the last entry.
                        n_pos = r_count;
                        if (w_below_limit) begin
                            n_count = r_count + CW'(1);
                            n_evict = 1'b0;
                            n_state = (r_count == '0) ? S_WRNEW : S_RD;
                        end else begin
                            n_evict = 1'b1;
                            n_state = (r_count == '0) ? S_RESP : S_RD;
                        end
                    end
                    CMD_DEQ, CMD_PEEK_MIN, CMD_PEEK_MAX, CMD_POP_IDX: begin
                        if (r_count == '0) begin
                            n_status = 1'b1;
                        end else if (r_cmd == CMD_DEQ) begin
                            w_req.advance = 1'b1;
                            n_count       = r_count - CW'(1);
                        end else begin
                            w_req.rd_en  = 1'b1;
                            w_req.rd_pos = (r_cmd == CMD_PEEK_MAX) ? r_count - CW'(1) : '0;
                            n_state      = S_FETCH;
                        end
                    end
                    CMD_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_FETCH: begin
                n_oidx = w_rd_entry.idx;
                if (r_cmd == CMD_POP_IDX) begin
                    w_req.advance = 1'b1;
                    n_count       = r_count - CW'(1);
                end else begin
                    n_oval = w_rd_entry.val;
                end
                n_state = S_RESP;
            end
            S_RD: begin
                w_req.rd_en  = 1'b1;
                w_req.rd_pos = r_pos - CW'(1);
                n_state      = S_CMP;
            end
            S_CMP: begin
                if (w_greater) begin
                    // A larger entry moves up one slot; on a full queue the first
                    // larger entry is the largest one and is simply dropped.
                    if (!r_evict) begin
                        w_req.wr_en    = 1'b1;
                        w_req.wr_pos   = r_pos;
                        w_req.wr_entry = w_rd_entry;
                    end
                    n_evict = 1'b0;
                    n_pos   = r_pos - CW'(1);
                    n_state = (r_pos == CW'(1)) ? S_WRNEW : S_RD;
                end else if (r_evict) begin
                    // Full and not smaller than the largest: drop the new entry.
                    n_state = S_RESP;
                end else begin
                    w_req.wr_en    = 1'b1;
                    w_req.wr_pos   = r_pos;
                    w_req.wr_entry = r_new;
                    n_state        = S_RESP;
                end
            end
            S_WRNEW: begin
                w_req.wr_en    = 1'b1;
                w_req.wr_pos   = r_pos;
                w_req.wr_entry = r_new;
                n_state        = S_RESP;
            end
            S_RESP: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_evict <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_evict <= n_evict;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_new    <= n_new;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_oidx   <= n_oidx;
        r_oval   <= n_oval;
    end

    // Configuration register: written on any completed config transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= MAX_SIZE_RESET;
        end else if (i_cfg.valid) begin
            r_max_size <= i_cfg.max_size;
        end
    end

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);

    // The count fields follow the stored count, which is settled by the time
    // the result is shown.
    assign o_out.valid       = (r_state == S_RESP);
    assign o_out.status      = r_status;
    assign o_out.out_index   = r_oidx;
    assign o_out.out_value   = r_oval;
    assign o_out.entry_count = 7'(r_count);
    assign o_out.is_empty    = (r_count == '0);
    assign o_out.is_full     = !w_below_limit;

endmodule

### rtl/bspq_checker.sv
// Port-level checker for the bounded sorted priority queue, bound to the top level.
// Depends on bspq_pkg and on the top level's channel ports.
`timescale 1ns / 1ps

module bspq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_status,
    input logic [15:0] i_out_index,
    input logic [31:0] i_out_value,
    input logic [6:0]  i_entry_count,
    input logic        i_is_empty
);
    import bspq_pkg::*;

    // One command at a time: the block never takes a command while a result waits.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input accepted while a result is pending");

    // An accepted command closes the input until its result has been taken.
    a_in_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input still ready after a command was accepted");

    // A failing command reports nothing and leaves an empty queue behind.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status) |->
            (i_out_index == 16'd0 && i_out_value == 32'd0 && i_is_empty))
        else $error("empty status with payload or stored entries");

    // The stored count can never exceed the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_entry_count) <= CAPACITY))
        else $error("entry count above capacity");

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_status) && $stable(i_out_index)
             && $stable(i_out_value) && $stable(i_entry_count)))
        else $error("stalled result changed");

endmodule

bind bounded_sorted_priority_queue bspq_checker u_bspq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_status      (o_out.status),
    .i_out_index   (o_out.out_index),
    .i_out_value   (o_out.out_value),
    .i_entry_count (o_out.entry_count),
    .i_is_empty    (o_out.is_empty)
);

### sim/tb.sv
// Self-checking testbench for bounded_sorted_priority_queue (keep the k smallest entries).
// Uses bspq_pkg and the channel interfaces from bspq_if; everything else is built in here.
`timescale 1ns / 1ps

module tb;
    import bspq_pkg::*;

    // Codes 6 and 7 are not assigned; the queue must answer them with a plain success.
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    // The limit sits well above the slowest correct run: every enqueue walking a
    // full store, plus the longest sender gaps and receiver stalls.
    localparam int CYCLE_LIMIT = 2_000_000;

    // One result transaction, laid out field by field as the output channel carries it.
    typedef struct packed {
        logic        status;
        logic [15:0] index;
        logic [31:0] value;
        logic [6:0]  count;
        logic        empty;
        logic        full;
    } t_answer;

    logic clk = 1'b0;
    logic rst_n;

    bspq_in_if  in_if();
    bspq_out_if out_if();
    bspq_cfg_if cfg_if();

    bounded_sorted_priority_queue dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow copy of the queue: the entries in ascending order and the size register.
    t_entry     held_entries[$];
    logic [6:0] held_max_size = MAX_SIZE_RESET;

    // Answers predicted at input acceptance, oldest first, waiting for their result transaction.
    t_answer awaited_answers[$];

    // Idling controls shared between the test tasks and the receiver process.
    bit sender_idle   = 1'b0;
    bit receiver_idle = 1'b0;
    int result_hold_cycles = 0;

    // Bookkeeping for the failure verdict and for the summary.
    int failures        = 0;
    int reported        = 0;
    int commands_sent   = 0;
    int results_checked = 0;
    int drops           = 0;
    int evictions       = 0;
    int empty_hits      = 0;
    int peak_count      = 0;
    int size_settings   = 0;
    int cycle_count     = 0;

    // True when entry a sorts at or before entry b: signed value first, then unsigned index.
    function automatic bit sorts_no_later(input t_entry a, input t_entry b);
        if (a.val != b.val) begin
            return $signed(a.val) < $signed(b.val);
        end
        return a.idx <= b.idx;
    endfunction

    // Applies one command to the shadow queue and returns the result it must produce.
    function automatic t_answer apply_command(input logic [2:0] cmd, input logic [15:0] idx,
                                              input logic [31:0] val);
        t_answer ans;
        t_entry  fresh;
        int      pos;
        int      lim;
        ans = '0;
        lim = (held_max_size < CAPACITY) ? int'(held_max_size) : CAPACITY;
        case (cmd)
            CMD_ENQ: begin
                fresh.idx = idx;
                fresh.val = val;
                pos = 0;
                // Equal entries go after the ones already stored.
                while (pos < held_entries.size() && sorts_no_later(held_entries[pos], fresh)) begin
                    pos++;
                end
                if (held_entries.size() < lim) begin
                    held_entries.insert(pos, fresh);
                end else if (pos < held_entries.size()) begin
                    // At or above the limit: the newcomer displaces the largest entry.
                    held_entries.insert(pos, fresh);
                    void'(held_entries.pop_back());
                    evictions++;
                end else begin
                    drops++;
                end
            end
            CMD_DEQ, CMD_PEEK_MIN, CMD_PEEK_MAX, CMD_POP_IDX: begin
                if (held_entries.size() == 0) begin
                    ans.status = 1'b1;
                    empty_hits++;
                end else if (cmd == CMD_DEQ) begin
                    void'(held_entries.pop_front());
                end else if (cmd == CMD_PEEK_MIN) begin
                    ans.index = held_entries[0].idx;
                    ans.value = held_entries[0].val;
                end else if (cmd == CMD_PEEK_MAX) begin
                    ans.index = held_entries[held_entries.size() - 1].idx;
                    ans.value = held_entries[held_entries.size() - 1].val;
                end else begin
                    // Pop reports only the index; the value field stays zero.
                    ans.index = held_entries[0].idx;
                    void'(held_entries.pop_front());
                end
            end
            CMD_CLEAR: held_entries.delete();
            default: ;
        endcase
        ans.count = 7'(held_entries.size());
        ans.empty = (held_entries.size() == 0);
        ans.full  = (held_entries.size() >= lim);
        if (held_entries.size() > peak_count) begin
            peak_count = held_entries.size();
        end
        return ans;
    endfunction

    // Idle length in cycles: mostly none or a few, now and then a long one.
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Values lean toward the extremes and toward a narrow band that produces ties.
    function automatic logic [31:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            case ($urandom_range(0, 4))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                default: return 32'h0001_0000;
            endcase
        end
        if (roll <= 3) return 32'($urandom_range(0, 7)) - 32'd4;
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_index();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if (roll <= 3) return 16'($urandom_range(0, 3));
        return 16'($urandom_range(0, 65535));
    endfunction

    // Enqueues take enq_pct percent; clears and spare codes are rare; the rest removes or reads.
    function automatic logic [2:0] pick_command(input int enq_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < enq_pct) return CMD_ENQ;
        if (roll == 99) return CMD_CLEAR;
        if (roll == 98) return $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
        case ($urandom_range(0, 3))
            0: return CMD_DEQ;
            1: return CMD_PEEK_MIN;
            2: return CMD_PEEK_MAX;
            default: return CMD_POP_IDX;
        endcase
    endfunction

    // Offers one command and returns at the clock edge where the transaction is accepted.
    // Valid is left high so a back-to-back command keeps it up without a glitch.
    task automatic send_command(input logic [2:0] cmd, input logic [15:0] idx,
                                input logic [31:0] val);
        int gap;
        gap = sender_idle ? pick_gap() : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.command    <= cmd;
        in_if.elem_index <= idx;
        in_if.elem_value <= val;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        awaited_answers.push_back(apply_command(cmd, idx, val));
        commands_sent++;
    endtask

    // Stops offering commands and waits until every predicted result has been taken.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (awaited_answers.size() != 0) @(posedge clk);
    endtask

    // Writes the size register; only called once the queue has gone quiet.
    task automatic set_max_size(input logic [6:0] size);
        cfg_if.valid    <= 1'b1;
        cfg_if.max_size <= size;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        held_max_size = size;
        size_settings++;
        cfg_if.valid <= 1'b0;
    endtask

    // Every read and removal on an empty queue, then the two unassigned codes.
    task automatic test_empty_queue();
        send_command(CMD_DEQ, pick_index(), pick_value());
        send_command(CMD_PEEK_MIN, pick_index(), pick_value());
        send_command(CMD_PEEK_MAX, pick_index(), pick_value());
        send_command(CMD_POP_IDX, pick_index(), pick_value());
        send_command(CMD_SPARE_A, 16'hFFFF, 32'hFFFF_FFFF);
        send_command(CMD_SPARE_B, 16'h0000, 32'h0000_0000);
        drain_results();
    endtask

    // Extreme values, a tie on value broken by index, and an exact duplicate.
    task automatic test_ordering();
        send_command(CMD_ENQ, 16'hFFFF, 32'h7FFF_FFFF);
        send_command(CMD_ENQ, 16'h0000, 32'h8000_0000);
        send_command(CMD_ENQ, 16'h0005, 32'h0000_0000);
        send_command(CMD_ENQ, 16'h0003, 32'h0000_0000);
        send_command(CMD_ENQ, 16'h0003, 32'h0000_0000);
        send_command(CMD_PEEK_MIN, 16'h0000, 32'h0000_0000);
        send_command(CMD_PEEK_MAX, 16'h0000, 32'h0000_0000);
        send_command(CMD_POP_IDX, 16'h0000, 32'h0000_0000);
        send_command(CMD_DEQ, 16'h0000, 32'h0000_0000);
        drain_results();
    endtask

    // The limit dropped below the current count, a limit of zero, and one above capacity.
    task automatic test_size_limits();
        // Three entries are stored, so the queue now behaves as full with a count of three.
        set_max_size(7'd1);
        send_command(CMD_ENQ, 16'h0002, 32'hFFFF_FFFF);
        send_command(CMD_ENQ, 16'h0004, 32'h0000_0000);
        send_command(CMD_ENQ, 16'h0004, 32'h0000_0000);
        send_command(CMD_PEEK_MAX, 16'h0000, 32'h0000_0000);
        send_command(CMD_CLEAR, 16'h0000, 32'h0000_0000);
        drain_results();
        set_max_size(7'd0);
        send_command(CMD_ENQ, 16'h0001, 32'h8000_0000);
        send_command(CMD_PEEK_MIN, 16'h0000, 32'h0000_0000);
        drain_results();
        set_max_size(7'd127);
        send_command(CMD_ENQ, 16'h0007, 32'h7FFF_FFFF);
        send_command(CMD_PEEK_MAX, 16'h0000, 32'h0000_0000);
        drain_results();
    endtask

    // The receiver stops taking results for a long stretch while commands keep coming, so
    // the queue cannot hand back its result and has to hold off its input.
    task automatic test_result_backpressure();
        sender_idle = 1'b0;
        result_hold_cycles = 250;
        repeat (10) send_command(CMD_ENQ, pick_index(), pick_value());
        drain_results();
    endtask

    // Random traffic in phases, one size setting per phase. A large limit followed by a
    // small one without a clear in between exercises a count above the limit.
    task automatic test_random_traffic();
        int sizes[10]   = '{64, 1, 2, 5, 127, 0, 48, 6, 16, 64};
        int enq_pcts[10] = '{85, 60, 65, 70, 85, 50, 90, 60, 70, 50};
        int lengths[10] = '{240, 100, 100, 120, 200, 50, 120, 130, 150, 150};
        int sent;
        logic [2:0] cmd;
        for (int phase = 0; phase < 10; phase++) begin
            set_max_size(7'(sizes[phase]));
            sent = 0;
            while (sent < lengths[phase]) begin
                // Fresh idling pattern every so often, including stretches with none at all.
                if (sent % 64 == 0) begin
                    sender_idle   = ($urandom_range(0, 3) != 0);
                    receiver_idle = ($urandom_range(0, 3) != 0);
                end
                cmd = pick_command(enq_pcts[phase]);
                send_command(cmd, pick_index(), pick_value());
                // Spare codes are ignored by the queue and do not count toward the phase length.
                if (cmd != CMD_SPARE_A && cmd != CMD_SPARE_B) begin
                    sent++;
                end
            end
            drain_results();
        end
    endtask

    // Receiver: takes results with random stalls, or holds off for a requested stretch.
    initial begin
        int stall_left;
        stall_left = 0;
        out_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (result_hold_cycles > 0) begin
                out_if.ready <= 1'b0;
                result_hold_cycles--;
            end else if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                if (receiver_idle) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Result checker: every accepted result is matched against the oldest prediction.
    always @(posedge clk) begin
        t_answer want;
        t_answer got;
        string   which;
        if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got = '{out_if.status, out_if.out_index, out_if.out_value, out_if.entry_count,
                    out_if.is_empty, out_if.is_full};
            results_checked++;
            if (awaited_answers.size() == 0) begin
                failures++;
                if (reported < 10) begin
                    $display("result %0d arrived with nothing expected: %p", results_checked, got);
                    reported++;
                end
            end else begin
                want = awaited_answers.pop_front();
                which = "";
                if (got.status !== want.status) which = {which, " status"};
                if (got.index !== want.index) which = {which, " out_index"};
                if (got.value !== want.value) which = {which, " out_value"};
                if (got.count !== want.count) which = {which, " entry_count"};
                if (got.empty !== want.empty) which = {which, " is_empty"};
                if (got.full !== want.full) which = {which, " is_full"};
                if (which != "") begin
                    failures++;
                    if (reported < 10) begin
                        $display("result %0d wrong in%s", results_checked, which);
                        $display("  expected st=%0d idx=%h val=%h cnt=%0d empty=%0d full=%0d",
                                 want.status, want.index, want.value, want.count,
                                 want.empty, want.full);
                        $display("  actual   st=%0d idx=%h val=%h cnt=%0d empty=%0d full=%0d",
                                 got.status, got.index, got.value, got.count,
                                 got.empty, got.full);
                        reported++;
                    end
                end
            end
        end
    end

    // Watchdog: a run that hangs is a failure.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("no progress within %0d cycles, %0d results still expected",
                     CYCLE_LIMIT, awaited_answers.size());
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        // Every input is known from time zero; reset is asserted once, at the start.
        rst_n            = 1'b0;
        in_if.valid      = 1'b0;
        in_if.command    = CMD_ENQ;
        in_if.elem_index = '0;
        in_if.elem_value = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.max_size  = MAX_SIZE_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_queue();
        test_ordering();
        test_size_limits();
        test_result_backpressure();
        test_random_traffic();

        // A stray late result would show up within one full enqueue walk.
        repeat (2 * CAPACITY + 8) @(posedge clk);
        if (awaited_answers.size() != 0) begin
            $display("%0d expected results never arrived", awaited_answers.size());
            failures += awaited_answers.size();
        end

        $display("Covered %0d commands over %0d size settings, %0d results checked.",
                 commands_sent, size_settings, results_checked);
        $display("Saw %0d drops, %0d evictions, %0d empty reads, queue depth up to %0d.",
                 drops, evictions, empty_hits, peak_count);
        if (failures == 0) begin
            $display("tb passed");
        end else begin
            $display("%0d failures", failures);
            $display("tb failed");
        end
        $finish;
    end

endmodule
